/* hw/rtl/pcid_pkg.sv */
// ----------------------------------------------------------------------------
// pcid_pkg
// Shared constants and types for the context-identifier allocator.
// ----------------------------------------------------------------------------
package pcid_pkg;

    localparam int DEF_NUM_IDS    = 64;
    localparam int DEF_NUM_SPACES = 256;

    localparam int SPACE_W  = 8;
    localparam int FRAME_W  = 40;
    localparam int CTX_W    = 6;
    localparam int CR3_W    = 64;
    localparam int CR3_ID_W = 12;
    localparam int CR3_PAD_W = CR3_W - 1 - FRAME_W - CR3_ID_W;

    localparam logic CMD_SELECT  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // update request into the LRU stack
    typedef struct packed {
        logic               sel_en;
        logic               rel_en;
        logic [SPACE_W-1:0] space;
    } pcid_req_t;

    // lookup result out of the LRU stack
    typedef struct packed {
        logic                hit;
        logic [CR3_ID_W-1:0] id;
        logic                tail_valid;
        logic [SPACE_W-1:0]  tail_owner;
    } pcid_info_t;

endpackage

/* hw/rtl/pcid_lru_allocator.sv */
// ----------------------------------------------------------------------------
// pcid_lru_allocator
// Hands out process-context identifiers with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output side is not
// stalled, and returns one result per request. A request passes an input
// register, then a single pass through the LRU stack (an owner match over
// all NUM_IDS-1 entries plus a one-step shift toward the victim end) writes
// the result register and updates the stack in the same cycle, so the next
// request always sees the updated order. Identifier 0 is reserved for the
// global space. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module pcid_lru_allocator import pcid_pkg::*;
#(
    parameter int NUM_IDS    = DEF_NUM_IDS,
    parameter int NUM_SPACES = DEF_NUM_SPACES
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SPACE_W-1:0]  cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [SPACE_W-1:0]  space_id,
    input  logic [FRAME_W-1:0]  root_frame,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [CTX_W-1:0]    context_id,
    output logic                no_flush,
    output logic [CR3_W-1:0]    cr3_word,
    output logic                evicted,
    output logic [SPACE_W-1:0]  evicted_space
);

    logic [SPACE_W-1:0] global_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_cmd_reg;
    logic [SPACE_W-1:0] s1_space_reg;
    logic [FRAME_W-1:0] s1_frame_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CTX_W-1:0]   ctx_reg,   ctx_next;
    logic               nf_reg,    nf_next;
    logic [CR3_W-1:0]   cr3_reg,   cr3_next;
    logic               ev_reg,    ev_next;
    logic [SPACE_W-1:0] evs_reg,   evs_next;

    logic       advance;
    logic       is_global;
    logic       in_range;
    pcid_req_t  req;
    pcid_info_t info;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            global_reg <= cfg_data;
        end
    end

    // input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg   <= command;
            s1_space_reg <= space_id;
            s1_frame_reg <= root_frame;
        end
    end

    // request decode
    assign is_global = (s1_cmd_reg == CMD_SELECT) && (s1_space_reg == global_reg);
    assign in_range  = 32'(s1_space_reg) < NUM_SPACES;

    assign req.space  = s1_space_reg;
    assign req.sel_en = advance && !is_global && in_range && (s1_cmd_reg == CMD_SELECT);
    assign req.rel_en = advance && in_range && (s1_cmd_reg == CMD_RELEASE);

    pcid_lru_stack #(
        .NUM_IDS (NUM_IDS)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .info  (info)
    );

    // result formation
    always_comb
    begin
        ctx_next = '0;
        nf_next  = 1'b0;
        cr3_next = '0;
        ev_next  = 1'b0;
        evs_next = '0;
        if (is_global)
        begin
            nf_next  = 1'b1;
            cr3_next = {1'b1, {CR3_PAD_W{1'b0}}, s1_frame_reg, {CR3_ID_W{1'b0}}};
        end
        else if (in_range && (s1_cmd_reg == CMD_SELECT))
        begin
            ctx_next = info.id[CTX_W-1:0];
            nf_next  = info.hit;
            cr3_next = {info.hit, {CR3_PAD_W{1'b0}}, s1_frame_reg, info.id};
            ev_next  = !info.hit && info.tail_valid;
            evs_next = ev_next ? info.tail_owner : '0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctx_reg <= ctx_next;
            nf_reg  <= nf_next;
            cr3_reg <= cr3_next;
            ev_reg  <= ev_next;
            evs_reg <= evs_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign context_id    = ctx_reg;
    assign no_flush      = nf_reg;
    assign cr3_word      = cr3_reg;
    assign evicted       = ev_reg;
    assign evicted_space = evs_reg;

endmodule

/* hw/rtl/pcid_lru_stack.sv */
// ----------------------------------------------------------------------------
// pcid_lru_stack
// Recency-ordered stack of identifiers 1..NUM_IDS-1 with owner tags.
// Entry 0 is the most recently used, the last entry is the victim.
// ----------------------------------------------------------------------------
module pcid_lru_stack import pcid_pkg::*;
#(
    parameter int NUM_IDS = DEF_NUM_IDS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  pcid_req_t  req,
    output pcid_info_t info
);

    localparam int ID_W  = $clog2(NUM_IDS);
    localparam int DEPTH = NUM_IDS - 1;
    localparam logic [DEPTH-1:0] TAIL_SEL = {1'b1, {(DEPTH-1){1'b0}}};

    logic [ID_W-1:0]    id_reg    [DEPTH];
    logic [ID_W-1:0]    id_next   [DEPTH];
    logic [SPACE_W-1:0] owner_reg [DEPTH];
    logic [SPACE_W-1:0] owner_next[DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;

    logic [DEPTH-1:0] hit_vec;
    logic [DEPTH-1:0] sel_vec;
    logic [DEPTH-1:0] shift_vec;
    logic             hit;
    logic [ID_W-1:0]  hit_id;
    logic [ID_W-1:0]  sel_id;

    // owner match across all entries
    always_comb
    begin
        hit_id = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            hit_vec[k] = valid_reg[k] && (owner_reg[k] == req.space);
            hit_id     = hit_id | ({ID_W{hit_vec[k]}} & id_reg[k]);
        end
    end

    assign hit     = |hit_vec;
    assign sel_vec = hit ? hit_vec : TAIL_SEL;
    assign sel_id  = hit ? hit_id : id_reg[DEPTH-1];

    // entries at or above the selected one shift down by one
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            shift_vec[k] = |(sel_vec >> k);
        end
    end

    always_comb
    begin
        id_next    = id_reg;
        owner_next = owner_reg;
        valid_next = valid_reg;
        if (req.sel_en)
        begin
            id_next[0]    = sel_id;
            owner_next[0] = req.space;
            valid_next[0] = 1'b1;
            for (int k = 1; k < DEPTH; k++)
            begin
                if (shift_vec[k])
                begin
                    id_next[k]    = id_reg[k-1];
                    owner_next[k] = owner_reg[k-1];
                    valid_next[k] = valid_reg[k-1];
                end
            end
        end
        else if (req.rel_en)
        begin
            valid_next = valid_reg & ~hit_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int k = 0; k < DEPTH; k++)
            begin
                id_reg[k] <= ID_W'(k + 1);
            end
        end
        else
        begin
            valid_reg <= valid_next;
            id_reg    <= id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
    end

    assign info.hit        = hit;
    assign info.id         = CR3_ID_W'(sel_id);
    assign info.tail_valid = valid_reg[DEPTH-1];
    assign info.tail_owner = owner_reg[DEPTH-1];

endmodule

/* hw/rtl/pcid_checker.sv */
// ----------------------------------------------------------------------------
// pcid_checker
// Port-level checks for the context-identifier allocator.
// ----------------------------------------------------------------------------
module pcid_checker import pcid_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [CTX_W-1:0]    context_id,
    input logic                no_flush,
    input logic [CR3_W-1:0]    cr3_word,
    input logic                evicted,
    input logic [SPACE_W-1:0]  evicted_space
);

    // an eviction always means a fresh identifier, so translations are flushed
    a_evict_flush: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !no_flush)
        else $error("eviction reported with no-flush set");

    // the CR3 word carries the same identifier and flush bit as the result
    a_cr3_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cr3_word[CR3_W-1] == no_flush)
                      && (cr3_word[CTX_W-1:0] == context_id))
        else $error("CR3 word disagrees with identifier or no-flush bit");

    a_evs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_space == '0)
        else $error("evicted space nonzero without eviction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cr3_word))
        else $error("stalled result dropped or changed");

endmodule

bind pcid_lru_allocator pcid_checker u_pcid_checker (.*);
